/* sv/sprite_line_scheduler_unit_defines.svh */
// assertion macros for the sprite line scheduler
`ifndef SPRITE_LINE_SCHEDULER_UNIT_DEFINES_SVH
`define SPRITE_LINE_SCHEDULER_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define SLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked against the cycle after the antecedent
`define SLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sls_pkg.sv */
package sls_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  localparam logic signed [15:0] TOP_ABSENT = 16'sh7fff;
  localparam logic [11:0] LINES_RESET = 12'd480;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FR_TOP,
    ST_FR_SORT_RD,
    ST_FR_SORT_CMP,
    ST_LN_PRUNE,
    ST_LN_ACT_CHK,
    ST_LN_ACT_POS,
    ST_LN_ACT_SHIFT,
    ST_LN_EMIT,
    ST_LN_OUT
  } sls_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic write_obj;
    logic fr_init;
    logic fr_top_step;
    logic srt_load;
    logic srt_step;
    logic ln_init;
    logic prune_step;
    logic act_pos_init;
    logic act_pos_step;
    logic act_shift_step;
    logic act_skip;
    logic emit_step;
    logic out_load;
  } sls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic fr_top_done;
    logic srt_done;
    logic srt_move;
    logic prune_done;
    logic act_more;
    logic act_full;
    logic pos_done;
    logic shift_done;
    logic emit_done;
    logic emit_hit;
  } sls_sts_t;

endpackage

/* sv/sls_ctrl.sv */
module sls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  sls_pkg::sls_sts_t sts,
  output sls_pkg::sls_cmd_t cmd
);

  sls_pkg::sls_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sls_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sls_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.op)
            sls_pkg::OP_FRAME: state_nxt = sls_pkg::ST_FR_TOP;
            sls_pkg::OP_LINE:  state_nxt = sls_pkg::ST_LN_PRUNE;
            default:           state_nxt = sls_pkg::ST_IDLE;
          endcase
        end
      end
      sls_pkg::ST_FR_TOP: if (sts.fr_top_done) state_nxt = sls_pkg::ST_FR_SORT_RD;
      sls_pkg::ST_FR_SORT_RD: begin
        if (sts.srt_done) state_nxt = sls_pkg::ST_IDLE;
        else state_nxt = sls_pkg::ST_FR_SORT_CMP;
      end
      sls_pkg::ST_FR_SORT_CMP: if (!sts.srt_move) state_nxt = sls_pkg::ST_FR_SORT_RD;
      sls_pkg::ST_LN_PRUNE: if (sts.prune_done) state_nxt = sls_pkg::ST_LN_ACT_CHK;
      sls_pkg::ST_LN_ACT_CHK: begin
        if (!sts.act_more) state_nxt = sls_pkg::ST_LN_EMIT;
        else if (!sts.act_full) state_nxt = sls_pkg::ST_LN_ACT_POS;
      end
      sls_pkg::ST_LN_ACT_POS: if (sts.pos_done) state_nxt = sls_pkg::ST_LN_ACT_SHIFT;
      sls_pkg::ST_LN_ACT_SHIFT: if (sts.shift_done) state_nxt = sls_pkg::ST_LN_ACT_CHK;
      sls_pkg::ST_LN_EMIT: begin
        if (sts.emit_done) state_nxt = sls_pkg::ST_IDLE;
        else if (sts.emit_hit) state_nxt = sls_pkg::ST_LN_OUT;
      end
      sls_pkg::ST_LN_OUT: if (out_free) state_nxt = sls_pkg::ST_LN_EMIT;
      default: state_nxt = sls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sls_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          unique case (sts.op)
            sls_pkg::OP_WRITE: cmd.write_obj = 1'b1;
            sls_pkg::OP_FRAME: cmd.fr_init = 1'b1;
            sls_pkg::OP_LINE:  cmd.ln_init = 1'b1;
            default: ;
          endcase
        end
      end
      sls_pkg::ST_FR_TOP: begin
        cmd.fr_top_step = 1'b1;
      end
      sls_pkg::ST_FR_SORT_RD: cmd.srt_load = !sts.srt_done;
      sls_pkg::ST_FR_SORT_CMP: cmd.srt_step = 1'b1;
      sls_pkg::ST_LN_PRUNE: cmd.prune_step = 1'b1;
      sls_pkg::ST_LN_ACT_CHK: begin
        cmd.act_pos_init = sts.act_more && !sts.act_full;
        cmd.act_skip = sts.act_more && sts.act_full;
      end
      sls_pkg::ST_LN_ACT_POS: cmd.act_pos_step = 1'b1;
      sls_pkg::ST_LN_ACT_SHIFT: cmd.act_shift_step = 1'b1;
      sls_pkg::ST_LN_EMIT: cmd.emit_step = 1'b1;
      sls_pkg::ST_LN_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

/* sv/sls_datapath.sv */
module sls_datapath #(
  parameter int NUM_OBJECTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sls_pkg::sls_cmd_t   cmd,
  output sls_pkg::sls_sts_t   sts,
  input  logic [11:0]         screen_lines,
  input  logic [1:0]          in_operation,
  input  logic [4:0]          in_slot,
  input  logic signed [15:0]  in_top_row,
  input  logic [11:0]         in_object_height,
  input  logic signed [15:0]  in_depth_order,
  input  logic                in_present,
  input  logic [11:0]         in_line_number,
  output logic [4:0]          res_slot,
  output logic [4:0]          res_pos,
  output logic                res_last
);

  localparam int IW = $clog2(NUM_OBJECTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] NUM_C = CW'(NUM_OBJECTS);
  localparam logic signed [15:0] TOP_ABSENT_L = sls_pkg::TOP_ABSENT;

  logic signed [15:0] top_r [NUM_OBJECTS];
  logic [11:0]        hgt_r [NUM_OBJECTS];
  logic signed [15:0] dep_r [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0] pres_r;
  logic signed [15:0] etop_r [NUM_OBJECTS];
  logic [IW-1:0]      sord_r [NUM_OBJECTS];
  logic [IW-1:0]      aord_r [NUM_OBJECTS];
  logic [CW-1:0]      live_r, acnt_r, nxt_r;

  logic [1:0]  op_r;
  logic signed [12:0] line_r;
  logic [CW-1:0] i_r, h_r, w_r, pos_r, j_r;
  logic [IW-1:0] v_r;
  logic [5:0]  n_r;
  logic [IW-1:0] hit_slot_r;

  // sort key, absent objects after every present one
  function automatic logic signed [17:0] key_of(input logic p, input logic signed [15:0] t);
    key_of = p ? 18'(t) : 18'sd65536;
  endfunction

  // does the given line lie before the object's end row (top plus height)
  function automatic logic covers(input logic signed [12:0] ln,
                                  input logic signed [15:0] t, input logic [11:0] hh);
    logic signed [17:0] bot;
    bot = 18'(t) + 18'(signed'({1'b0, hh}));
    covers = 18'(ln) < bot;
  endfunction

  logic [IW-1:0] i_ix, hm1_ix, pos_ix, j_ix, jm1_ix, nxt_ix;
  assign i_ix   = i_r[IW-1:0];
  assign hm1_ix = IW'(h_r - CW'(1));
  assign pos_ix = pos_r[IW-1:0];
  assign j_ix   = j_r[IW-1:0];
  assign jm1_ix = IW'(j_r - CW'(1));
  assign nxt_ix = nxt_r[IW-1:0];

  logic [IW-1:0] prev_s, cand_s, a_s;
  logic signed [17:0] key_v, key_prev;
  logic signed [17:0] sum_top;
  logic srt_move;
  logic a_cov;

  assign prev_s   = sord_r[hm1_ix];
  assign key_v    = key_of(pres_r[v_r], etop_r[v_r]);
  assign key_prev = key_of(pres_r[prev_s], etop_r[prev_s]);
  assign srt_move = (h_r != '0) && (key_v < key_prev);
  assign cand_s   = sord_r[nxt_ix];
  assign a_s      = aord_r[i_ix];
  assign a_cov    = covers(line_r, etop_r[a_s], hgt_r[a_s]);
  assign sum_top  = 18'(top_r[i_ix]) + 18'(signed'({1'b0, hgt_r[i_ix]}));

  always_comb begin
    sts = '0;
    sts.op          = cmd.latch_in ? in_operation : op_r;
    sts.fr_top_done = (i_r == NUM_C - CW'(1));
    sts.srt_done    = (i_r == NUM_C);
    sts.srt_move    = srt_move;
    sts.prune_done  = (i_r >= acnt_r);
    sts.act_more    = (nxt_r < live_r) && (18'(line_r) >= 18'(etop_r[cand_s]));
    sts.act_full    = (acnt_r >= NUM_C);
    sts.pos_done    = (pos_r >= acnt_r) || !(dep_r[aord_r[pos_ix]] > dep_r[v_r]);
    sts.shift_done  = (j_r <= pos_r);
    sts.emit_done   = (i_r >= acnt_r) || (n_r == 6'd32);
    sts.emit_hit    = a_cov;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= '0;
      live_r <= '0;
      acnt_r <= '0;
      nxt_r  <= '0;
      for (int k = 0; k < NUM_OBJECTS; k++) begin
        etop_r[k] <= TOP_ABSENT_L;
        sord_r[k] <= IW'(k);
        top_r[k] <= '0;
        hgt_r[k] <= '0;
        dep_r[k] <= '0;
      end
    end else begin
      if (cmd.write_obj && (32'(in_slot) < NUM_OBJECTS)) begin
        top_r[IW'(in_slot)]  <= in_top_row;
        hgt_r[IW'(in_slot)]  <= in_object_height;
        dep_r[IW'(in_slot)]  <= in_depth_order;
        pres_r[IW'(in_slot)] <= in_present;
      end
      if (cmd.fr_init) live_r <= '0;
      if (cmd.fr_top_step) begin
        if (pres_r[i_ix]) begin
          etop_r[i_ix] <= (sum_top >= 0) ? top_r[i_ix]
                                         : 16'(signed'({4'b0, screen_lines}) + 16'sd1);
          live_r <= live_r + CW'(1);
        end else begin
          etop_r[i_ix] <= TOP_ABSENT_L;
        end
      end
      if (cmd.srt_step) begin
        if (srt_move) sord_r[h_r[IW-1:0]] <= prev_s;
        else sord_r[h_r[IW-1:0]] <= v_r;
      end
      if (cmd.fr_init) begin
        acnt_r <= '0;
        nxt_r  <= '0;
      end
      if (cmd.prune_step) begin
        if (i_r < acnt_r) begin
          if (a_cov) aord_r[w_r[IW-1:0]] <= a_s;
        end else begin
          acnt_r <= w_r;
        end
      end
      if (cmd.act_skip) nxt_r <= nxt_r + CW'(1);
      if (cmd.act_shift_step) begin
        if (j_r > pos_r) aord_r[j_ix] <= aord_r[jm1_ix];
        else begin
          aord_r[pos_ix] <= v_r;
          acnt_r <= acnt_r + CW'(1);
          nxt_r  <= nxt_r + CW'(1);
        end
      end
    end
  end

  // sequencing counters and latched item fields
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_operation;
      line_r <= 13'(signed'({1'b0, in_line_number}));
    end
    if (cmd.fr_init) i_r <= '0;
    if (cmd.fr_top_step) i_r <= (i_r == NUM_C - CW'(1)) ? CW'(1) : i_r + CW'(1);
    if (cmd.srt_load) begin
      v_r <= sord_r[i_ix];
      h_r <= i_r;
    end
    if (cmd.srt_step) begin
      if (srt_move) h_r <= h_r - CW'(1);
      else i_r <= i_r + CW'(1);
    end
    if (cmd.ln_init) begin
      i_r <= '0;
      w_r <= '0;
    end
    if (cmd.prune_step) begin
      if (i_r < acnt_r) begin
        i_r <= i_r + CW'(1);
        if (a_cov) w_r <= w_r + CW'(1);
      end else begin
        i_r <= '0;
        n_r <= '0;
      end
    end
    if (cmd.act_pos_init) begin
      v_r   <= cand_s;
      pos_r <= '0;
      j_r   <= acnt_r;
    end
    if (cmd.act_pos_step && !sts.pos_done) pos_r <= pos_r + CW'(1);
    if (cmd.act_shift_step && (j_r > pos_r)) j_r <= j_r - CW'(1);
    if (cmd.emit_step && !sts.emit_done) begin
      i_r <= i_r + CW'(1);
      if (a_cov) hit_slot_r <= a_s;
    end
    if (cmd.out_load) n_r <= n_r + 6'd1;
  end

  // a hit is final when no later active entry covers the line, or when it is the 32nd result
  logic later_cov;
  always_comb begin
    later_cov = 1'b0;
    for (int k = 0; k < NUM_OBJECTS; k++) begin
      if ((CW'(k) >= i_r) && (CW'(k) < acnt_r)
          && covers(line_r, etop_r[aord_r[k]], hgt_r[aord_r[k]]))
        later_cov = 1'b1;
    end
  end

  assign res_slot = 5'(hit_slot_r);
  assign res_pos  = n_r[4:0];
  assign res_last = !later_cov || (n_r == 6'd31);

endmodule

/* sv/sprite_line_scheduler_unit.sv */
// channel | dir | beat fields
// in_     | in  | operation slot top_row object_height depth_order present line_number
// out_    | out | object_slot draw_position last
// cfg_    | in  | screen_lines, written when cfg_we is high
// write item: stores one object; frame item: after the accept, top fixing over all n objects
//   and an insertion sort that reads each entry k and compares it back against earlier entries,
//   with n = NUM_OBJECTS; no new item is taken until the sort ends
// line item: prune walk over the active entries, per activated object a depth search and shift,
//   then an emit walk over the active entries that hands out each result in turn
// reset clears control state and the object table; out_ stalls hold the emit walk
module sprite_line_scheduler_unit #(
  parameter int NUM_OBJECTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_slot,
  input  logic signed [15:0] in_top_row,
  input  logic [11:0]        in_object_height,
  input  logic signed [15:0] in_depth_order,
  input  logic               in_present,
  input  logic [11:0]        in_line_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_object_slot,
  output logic [4:0]         out_draw_position,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [11:0]        cfg_screen_lines
);

  `include "sprite_line_scheduler_unit_defines.svh"

  sls_pkg::sls_cmd_t cmd;
  sls_pkg::sls_sts_t sts;
  logic [11:0] lines_r;
  logic [4:0] res_slot, res_pos;
  logic res_last, out_free;
  logic [4:0] oslot_r, opos_r;
  logic olast_r, ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) lines_r <= sls_pkg::LINES_RESET;
    else if (cfg_we) lines_r <= cfg_screen_lines;
  end

  assign out_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_ready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oslot_r <= res_slot;
      opos_r  <= res_pos;
      olast_r <= res_last;
    end
  end

  sls_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_free(out_free), .sts(sts), .cmd(cmd)
  );

  sls_datapath #(.NUM_OBJECTS(NUM_OBJECTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .screen_lines(lines_r),
    .in_operation(in_operation), .in_slot(in_slot), .in_top_row(in_top_row),
    .in_object_height(in_object_height), .in_depth_order(in_depth_order),
    .in_present(in_present), .in_line_number(in_line_number),
    .res_slot(res_slot), .res_pos(res_pos), .res_last(res_last)
  );

  assign out_valid         = ovalid_r;
  assign out_object_slot   = oslot_r;
  assign out_draw_position = opos_r;
  assign out_last          = olast_r;

  `SLS_ASSERT_IMP(a_no_accept_busy, cmd.out_load, !in_ready, "result loaded while idle")
  `SLS_ASSERT_NXT(a_out_load_valid, cmd.out_load, out_valid, "loaded result not shown")
  `SLS_ASSERT_IMP(a_ready_no_load, in_ready, !cmd.out_load, "idle state loads result")

endmodule
